>>> sv/lcg_id_text_codec_defines.svh
// assertion macros shared by the codec checker
`ifndef LCG_ID_TEXT_CODEC_DEFINES_SVH
`define LCG_ID_TEXT_CODEC_DEFINES_SVH

// same-cycle implication, held off during reset
`define LCGC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcgc check failed");

// next-cycle implication, held off during reset
`define LCGC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcgc check failed");

`endif

>>> sv/lcgc_pkg.sv
// shared types, constants and symbol tables of the id text codec
package lcgc_pkg;

  localparam int unsigned ID_W        = 64;
  localparam int unsigned HALF_W      = ID_W / 2;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned SYM_W       = 6;
  localparam int unsigned SYMS        = 1 << SYM_W;
  localparam int unsigned CODE_CHARS  = 11;
  localparam int unsigned TOP_SYM_MAX = 15;
  localparam int unsigned CNT_W       = $clog2(CODE_CHARS + 1);
  localparam int unsigned SH_W        = $clog2(ID_W);

  localparam logic [ID_W-1:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [ID_W-1:0] LCG_ADD = 64'd1442695040888963407;
  localparam logic [ID_W-1:0] LCG_INV = 64'd13877824140714322085;

  localparam logic [CHAR_W-1:0] ALPHABET [SYMS] = '{
    "I", "N", "A", "S", "E", "i", "r", "F",
    "n", "M", "b", "T", "W", "f", "G", "Q",
    "a", "O", "4", "B", "v", "c", "h", "K",
    "s", "0", "7", "5", "6", "D", "q", "z",
    "e", "V", "C", "X", "3", "8", "9", "R",
    "o", "k", "m", "U", "Y", "p", "x", "1",
    "J", "Z", "l", "t", "2", "y", "j", "d",
    "P", "L", "H", "w", "-", "_", "u", "g"
  };

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic {
    KIND_CHAR = 1'b0,
    KIND_ID   = 1'b1
  } kind_e;

  // one unit of work for the back end
  typedef struct packed {
    logic            dec;
    logic            ok;
    logic [ID_W-1:0] operand;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] val;
  } sym_t;

  // reverse alphabet lookup
  function automatic sym_t char_to_sym(input logic [CHAR_W-1:0] ch);
    sym_t r;
    r = '0;
    for (int k = 0; k < SYMS; k++) begin
      if (ALPHABET[k] == ch) begin
        r.hit = 1'b1;
        r.val = SYM_W'(k);
      end
    end
    return r;
  endfunction

endpackage

>>> sv/lcgc_front.sv
// front end: takes requests, gathers decode runs and issues jobs
module lcgc_front
  import lcgc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic              full_i,
  input  logic              op_i,
  input  logic [ID_W-1:0]   id_in_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic              in_last_i,
  output logic              wr_o,
  output job_t              job_o
);

  logic [ID_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             err_q, err_d;
  logic             accept;
  sym_t             sym;
  logic [SH_W-1:0]  sh;

  assign accept = push_i && !full_i;
  assign sym    = char_to_sym(in_char_i);
  assign sh     = SH_W'(cnt_q) * SH_W'(SYM_W);

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    err_d = err_q;
    wr_o  = 1'b0;
    job_o = '0;
    if (accept) begin
      if (op_i == OP_ENCODE) begin
        wr_o          = 1'b1;
        job_o.operand = id_in_i;
      end else begin
        // characters past the code length are neither checked nor kept
        if (cnt_q < CNT_W'(CODE_CHARS)) begin
          if (!sym.hit) begin
            err_d = 1'b1;
          end else begin
            if (cnt_q == CNT_W'(CODE_CHARS - 1) && sym.val > SYM_W'(TOP_SYM_MAX)) begin
              err_d = 1'b1;
            end
            acc_d = acc_q | (ID_W'(sym.val) << sh);
          end
          cnt_d = cnt_q + 1'b1;
        end
        if (in_last_i) begin
          wr_o          = 1'b1;
          job_o.dec     = 1'b1;
          job_o.ok      = (cnt_d == CNT_W'(CODE_CHARS)) && !err_d;
          job_o.operand = acc_d;
          acc_d         = '0;
          cnt_d         = '0;
          err_d         = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      cnt_q <= '0;
      err_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

endmodule

>>> sv/lcgc_queue.sv
// short job queue between front and back end
module lcgc_queue
  import lcgc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  job_t      wr_data_i,
  input  logic      rd_i,
  output job_t      rd_data_o,
  output q_status_t status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign rd_data_o       = mem_q[rd_ptr_q];
  assign status_o.full   = (cnt_q == CW'(DEPTH));
  assign status_o.empty  = (cnt_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_i, rd_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

>>> sv/lcgc_back.sv
// back end: shared 32x32 multiply sequence, character emitter, output register
module lcgc_back
  import lcgc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  q_status_t         q_status_i,
  input  job_t              q_data_i,
  output logic              q_rd_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic              kind_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o,
  output logic [ID_W-1:0]   id_out_o,
  output logic              valid_res_o
);

  typedef enum logic [1:0] {
    CMP_IDLE,
    CMP_RUN,
    CMP_DONE
  } cmp_state_e;

  localparam logic [2:0] STEP_LO_LO = 3'd0;
  localparam logic [2:0] STEP_HI_LO = 3'd1;
  localparam logic [2:0] STEP_LO_HI = 3'd2;
  localparam logic [2:0] STEP_SUM   = 3'd3;
  localparam logic [2:0] STEP_FIN   = 3'd4;

  // multiply sequence
  cmp_state_e        st_q, st_d;
  logic [2:0]        step_q, step_d;
  logic              dec_q, dec_d;
  logic              ok_q, ok_d;
  logic [ID_W-1:0]   x_q, x_d;
  logic [ID_W-1:0]   p_q, p_d;
  logic [HALF_W-1:0] c_q, c_d;
  logic [ID_W-1:0]   r_q, r_d;
  logic [ID_W-1:0]   kmul;
  logic [HALF_W-1:0] ma, mb;
  logic [ID_W-1:0]   prod;

  // emitter
  logic              em_act_q, em_act_d;
  logic              em_dec_q, em_dec_d;
  logic              em_ok_q, em_ok_d;
  logic [ID_W-1:0]   em_t_q, em_t_d;
  logic [CNT_W-1:0]  em_cnt_q, em_cnt_d;

  // output register
  logic              ov_q, ov_d;
  logic              kind_q, kind_d;
  logic [CHAR_W-1:0] char_q, char_d;
  logic              last_q, last_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic              vld_q, vld_d;

  logic              slot_free, fire, fin, load;

  assign kmul = dec_q ? LCG_INV : LCG_MUL;

  always_comb begin
    unique case (step_q)
      STEP_HI_LO: begin
        ma = x_q[ID_W-1:HALF_W];
        mb = kmul[HALF_W-1:0];
      end
      STEP_LO_HI: begin
        ma = x_q[HALF_W-1:0];
        mb = kmul[ID_W-1:HALF_W];
      end
      default: begin
        ma = x_q[HALF_W-1:0];
        mb = kmul[HALF_W-1:0];
      end
    endcase
  end

  assign prod = {{HALF_W{1'b0}}, ma} * {{HALF_W{1'b0}}, mb};

  assign slot_free = !ov_q || pop_i;
  assign fire      = em_act_q && slot_free;
  assign fin       = fire && (em_dec_q || em_cnt_q == CNT_W'(CODE_CHARS - 1));
  assign load      = (st_q == CMP_DONE) && (!em_act_q || fin);

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    dec_d  = dec_q;
    ok_d   = ok_q;
    x_d    = x_q;
    p_d    = p_q;
    c_d    = c_q;
    r_d    = r_q;
    q_rd_o = 1'b0;
    unique case (st_q)
      CMP_IDLE: begin
        if (!q_status_i.empty) begin
          q_rd_o = 1'b1;
          dec_d  = q_data_i.dec;
          ok_d   = q_data_i.ok;
          x_d    = q_data_i.dec ? (~q_data_i.operand - LCG_ADD) : q_data_i.operand;
          step_d = STEP_LO_LO;
          st_d   = CMP_RUN;
        end
      end
      CMP_RUN: begin
        unique case (step_q)
          STEP_LO_LO: begin
            p_d    = prod;
            step_d = STEP_HI_LO;
          end
          STEP_HI_LO: begin
            c_d    = prod[HALF_W-1:0];
            step_d = STEP_LO_HI;
          end
          STEP_LO_HI: begin
            c_d    = c_q + prod[HALF_W-1:0];
            step_d = STEP_SUM;
          end
          STEP_SUM: begin
            r_d    = p_q + {c_q, {HALF_W{1'b0}}};
            step_d = STEP_FIN;
          end
          STEP_FIN: begin
            if (dec_q) begin
              r_d = ok_q ? r_q : '0;
            end else begin
              r_d = ~(r_q + LCG_ADD);
            end
            st_d = CMP_DONE;
          end
          default: begin
            step_d = STEP_LO_LO;
            st_d   = CMP_IDLE;
          end
        endcase
      end
      CMP_DONE: begin
        if (load) begin
          st_d = CMP_IDLE;
        end
      end
      default: st_d = CMP_IDLE;
    endcase
  end

  always_comb begin
    em_act_d = em_act_q;
    em_dec_d = em_dec_q;
    em_ok_d  = em_ok_q;
    em_t_d   = em_t_q;
    em_cnt_d = em_cnt_q;
    ov_d     = ov_q;
    kind_d   = kind_q;
    char_d   = char_q;
    last_d   = last_q;
    id_d     = id_q;
    vld_d    = vld_q;
    if (fire) begin
      ov_d = 1'b1;
      if (em_dec_q) begin
        kind_d = KIND_ID;
        char_d = '0;
        last_d = 1'b1;
        id_d   = em_t_q;
        vld_d  = em_ok_q;
      end else begin
        kind_d = KIND_CHAR;
        char_d = ALPHABET[em_t_q[SYM_W-1:0]];
        last_d = (em_cnt_q == CNT_W'(CODE_CHARS - 1));
        id_d   = '0;
        vld_d  = 1'b0;
      end
      em_t_d   = em_t_q >> SYM_W;
      em_cnt_d = em_cnt_q + 1'b1;
    end else if (pop_i) begin
      ov_d = 1'b0;
    end
    if (load) begin
      em_act_d = 1'b1;
      em_dec_d = dec_q;
      em_ok_d  = ok_q;
      em_t_d   = r_q;
      em_cnt_d = '0;
    end else if (fin) begin
      em_act_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= CMP_IDLE;
      step_q   <= STEP_LO_LO;
      em_act_q <= 1'b0;
      em_cnt_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      st_q     <= st_d;
      step_q   <= step_d;
      em_act_q <= em_act_d;
      em_cnt_q <= em_cnt_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dec_q    <= dec_d;
    ok_q     <= ok_d;
    x_q      <= x_d;
    p_q      <= p_d;
    c_q      <= c_d;
    r_q      <= r_d;
    em_dec_q <= em_dec_d;
    em_ok_q  <= em_ok_d;
    em_t_q   <= em_t_d;
    kind_q   <= kind_d;
    char_q   <= char_d;
    last_q   <= last_d;
    id_q     <= id_d;
    vld_q    <= vld_d;
  end

  assign empty_o     = !ov_q;
  assign kind_o      = kind_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign id_out_o    = id_q;
  assign valid_res_o = vld_q;

endmodule

>>> sv/lcg_id_text_codec.sv
// top level of the id text codec
// Encode requests (op 0) scramble a 64-bit id as NOT(id*A + C) mod 2^64 and
// give eleven alphabet characters, lowest 6 bits first, the last one flagged.
// Decode requests (op 1) carry one character each; the request marked last
// gives one id result with a valid flag (id 0 when the code is malformed).
// Both sides look like queues: push/full in, empty/pop out. The front end
// takes one request per cycle while the job queue has room and gathers decode
// runs; completed jobs wait in a QUEUE_DEPTH-entry queue. The back end runs
// each job through five steps of one shared 32x32 multiplier, overlapped
// with the emitter of the previous job. The output port moves one result per
// cycle while pop is held high; decode characters are taken once per cycle
// while the job queue has room. There is no clearing pass after reset.
module lcg_id_text_codec
  import lcgc_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // request side
  input  logic              push,
  output logic              full,
  input  logic              op_i,
  input  logic [ID_W-1:0]   id_in_i,
  input  logic [CHAR_W-1:0] in_char_i,
  input  logic              in_last_i,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic              kind_o,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              out_last_o,
  output logic [ID_W-1:0]   id_out_o,
  output logic              valid_res_o
);

  // front to queue
  logic      wr;
  job_t      wr_job;
  // queue to back
  logic      q_rd;
  job_t      q_job;
  q_status_t q_status;

  // request is taken whenever the job queue has room
  assign full = q_status.full;

  lcgc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_i    (q_status.full),
    .op_i      (op_i),
    .id_in_i   (id_in_i),
    .in_char_i (in_char_i),
    .in_last_i (in_last_i),
    .wr_o      (wr),
    .job_o     (wr_job)
  );

  lcgc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_job),
    .rd_i      (q_rd),
    .rd_data_o (q_job),
    .status_o  (q_status)
  );

  // multiply sequence plus emitter; its output register parts the result side
  lcgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .q_data_i    (q_job),
    .q_rd_o      (q_rd),
    .pop_i       (pop),
    .empty_o     (empty),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .id_out_o    (id_out_o),
    .valid_res_o (valid_res_o)
  );

endmodule

>>> sv/lcgc_checker.sv
// port checker for the id text codec and its bind
`include "lcg_id_text_codec_defines.svh"

module lcgc_checker
  import lcgc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              empty_i,
  input logic              pop_i,
  input logic              kind_i,
  input logic [CHAR_W-1:0] out_char_i,
  input logic              out_last_i,
  input logic [ID_W-1:0]   id_out_i,
  input logic              valid_res_i
);

  `LCGC_ASSERT_IMPLY(a_char_res_clean, clk_i, rst_ni,
    !empty_i && kind_i == KIND_CHAR,
    !valid_res_i && id_out_i == '0 && out_char_i != '0)
  `LCGC_ASSERT_IMPLY(a_id_res_shape, clk_i, rst_ni,
    !empty_i && kind_i == KIND_ID,
    out_last_i && out_char_i == '0)
  `LCGC_ASSERT_IMPLY(a_bad_id_zero, clk_i, rst_ni,
    !empty_i && kind_i == KIND_ID && !valid_res_i,
    id_out_i == '0)
  `LCGC_ASSERT_NEXT(a_res_held, clk_i, rst_ni,
    !empty_i && !pop_i,
    !empty_i && $stable(out_char_i) && $stable(id_out_i))

endmodule

bind lcg_id_text_codec lcgc_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty_i     (empty),
  .pop_i       (pop),
  .kind_i      (kind_o),
  .out_char_i  (out_char_o),
  .out_last_i  (out_last_o),
  .id_out_i    (id_out_o),
  .valid_res_i (valid_res_o)
);

>>> tb/sv/testbench.sv
// self-checking bench for the id text codec: directed table, then random requests
module testbench;
  import lcgc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // scrambling constants, kept apart from the package copies
  localparam logic [ID_W-1:0] SCRAMBLE_MUL = 64'd6364136223846793005;
  localparam logic [ID_W-1:0] SCRAMBLE_ADD = 64'd1442695040888963407;
  localparam logic [ID_W-1:0] SCRAMBLE_INV = 64'd13877824140714322085;

  // permuted alphabet, symbol 0 in the top byte
  localparam logic [8*SYMS-1:0] SYMBOLS = {
    "INASEirF", "nMbTWfGQ", "aO4BvchK", "s0756Dqz",
    "eVCX389R", "okmUYpx1", "JZlt2yjd", "PLHw-_ug"
  };

  localparam int STALL_LIMIT  = 4000;  // cycles with no request or result moving
  localparam int DRAIN_CYCLES = 32;    // back-end latency plus margin
  localparam int RANDOM_ITEMS = 135;   // split evenly over the three random phases

  typedef struct packed {
    kind_e             kind;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic [ID_W-1:0]   id;
    logic              valid;
  } code_result_t;

  // one line of the opening table; malformed rows carry a typed-in answer
  typedef struct packed {
    op_e               op;
    logic [ID_W-1:0]   id;
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              malformed;
  } opening_row_t;

  localparam int OPENING_ROWS = 26;

  opening_row_t opening_rows [OPENING_ROWS] = '{
    // one-character run holding a byte outside the alphabet
    '{OP_DECODE, 64'd0, 8'h00, 1'b1, 1'b1},
    // smallest id
    '{OP_ENCODE, 64'd0, 8'h00, 1'b0, 1'b0},
    // run of top symbols, interrupted by an encode of the largest id
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "g", 1'b0, 1'b0},
    // eleventh character at the largest value allowed there
    '{OP_DECODE, 64'd0, "Q", 1'b0, 1'b0},
    // twelfth character is ignored even though it is not a symbol
    '{OP_DECODE, 64'd0, 8'hFF, 1'b1, 1'b0},
    // lowest symbols, eleventh one just too large
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "I", 1'b0, 1'b0},
    '{OP_DECODE, 64'd0, "a", 1'b1, 1'b1}
  };

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              push      = 1'b0;
  logic              full;
  logic              op_i      = 1'b0;
  logic [ID_W-1:0]   id_in_i   = '0;
  logic [CHAR_W-1:0] in_char_i = '0;
  logic              in_last_i = 1'b0;
  logic              empty;
  logic              pop       = 1'b0;
  logic              kind_o;
  logic [CHAR_W-1:0] out_char_o;
  logic              out_last_o;
  logic [ID_W-1:0]   id_out_o;
  logic              valid_res_o;

  // model copy of the decode run in progress
  logic [ID_W-1:0]   gathered_bits;
  logic [CNT_W-1:0]  gathered_count;
  logic              gathered_bad;

  code_result_t      awaited_results [$];
  int                mismatches    = 0;
  int                items_sent    = 0;
  int                send_gap_pct  = 0;
  int                pop_gap_pct   = 0;

  lcg_id_text_codec DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .op_i        (op_i),
    .id_in_i     (id_in_i),
    .in_char_i   (in_char_i),
    .in_last_i   (in_last_i),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .out_char_o  (out_char_o),
    .out_last_o  (out_last_o),
    .id_out_o    (id_out_o),
    .valid_res_o (valid_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [ID_W-1:0] scramble_id(input logic [ID_W-1:0] id);
    return ~(id * SCRAMBLE_MUL + SCRAMBLE_ADD);
  endfunction

  function automatic logic [CHAR_W-1:0] symbol_char(input int k);
    return SYMBOLS[8*(SYMS-1-k) +: 8];
  endfunction

  // symbol value of a byte, or -1 when it is not in the alphabet
  function automatic int symbol_of(input logic [CHAR_W-1:0] ch);
    int found;
    found = -1;
    for (int k = 0; k < SYMS; k++) begin
      if (symbol_char(k) == ch) found = k;
    end
    return found;
  endfunction

  function automatic void clear_run();
    gathered_bits  = '0;
    gathered_count = '0;
    gathered_bad   = 1'b0;
  endfunction

  // works out the results one accepted request causes and queues them
  function automatic void lcg_codec_step(input op_e op, input logic [ID_W-1:0] id,
                                         input logic [CHAR_W-1:0] ch, input logic last);
    logic [ID_W-1:0] t;
    code_result_t    r;
    int              sym;
    logic            ok;
    if (op == OP_ENCODE) begin
      t = scramble_id(id);
      for (int k = 0; k < CODE_CHARS; k++) begin
        r = '{KIND_CHAR, symbol_char(int'(t[SYM_W-1:0])), k == CODE_CHARS - 1, '0, 1'b0};
        awaited_results.push_back(r);
        t = t >> SYM_W;
      end
    end else begin
      // characters past the eleventh are neither checked nor gathered
      if (gathered_count < CNT_W'(CODE_CHARS)) begin
        sym = symbol_of(ch);
        if (sym < 0) begin
          gathered_bad = 1'b1;
        end else begin
          if (gathered_count == CNT_W'(CODE_CHARS - 1) && sym > TOP_SYM_MAX) begin
            gathered_bad = 1'b1;
          end
          gathered_bits |= ID_W'(sym) << (SYM_W * gathered_count);
        end
        gathered_count++;
      end
      if (last) begin
        ok = (gathered_count >= CNT_W'(CODE_CHARS)) && !gathered_bad;
        r = '{KIND_ID, '0, 1'b1, '0, ok};
        if (ok) r.id = (~gathered_bits - SCRAMBLE_ADD) * SCRAMBLE_INV;
        awaited_results.push_back(r);
        clear_run();
      end
    end
  endfunction

  // offers one request after a random gap; unused fields carry noise
  task automatic send_request(input op_e op, input logic [ID_W-1:0] id,
                              input logic [CHAR_W-1:0] ch, input logic last,
                              input logic malformed);
    logic [ID_W-1:0]   id_drv;
    logic [CHAR_W-1:0] ch_drv;
    logic              last_drv;
    code_result_t      typed;
    id_drv   = (op == OP_ENCODE) ? id : {$urandom, $urandom};
    ch_drv   = (op == OP_DECODE) ? ch : CHAR_W'($urandom);
    last_drv = (op == OP_DECODE) ? last : 1'($urandom);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    op_i      <= op;
    id_in_i   <= id_drv;
    in_char_i <= ch_drv;
    in_last_i <= last_drv;
    do @(posedge clk_i); while (full);
    items_sent++;
    lcg_codec_step(op, id_drv, ch_drv, last_drv);
    // malformed rows: the answer is plain, so the typed one replaces the model's
    if (malformed) begin
      typed = '{KIND_ID, '0, 1'b1, '0, 1'b0};
      void'(awaited_results.pop_back());
      awaited_results.push_back(typed);
    end
  endtask

  // holds the request side until every queued result has come out
  task automatic settle_results();
    push <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  // one random encode, a stray character, or a whole decode run
  task automatic random_burst();
    logic [ID_W-1:0]   id;
    logic [ID_W-1:0]   t;
    logic [CHAR_W-1:0] text [16];
    int                pick;
    int                flaw;
    int                n;
    pick = $urandom_range(0, 99);
    id   = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) id = $urandom_range(0, 1) ? '1 : '0;
    if (pick < 25) begin
      send_request(OP_ENCODE, id, '0, 1'b0, 1'b0);
    end else if (pick < 32) begin
      // stray byte; without the last mark it leaves a run half built
      send_request(OP_DECODE, '0, CHAR_W'($urandom), $urandom_range(0, 3) == 0, 1'b0);
    end else begin
      // well-formed code of a random id, sometimes damaged
      t = scramble_id(id);
      for (int k = 0; k < 16; k++) begin
        text[k] = (k < CODE_CHARS) ? symbol_char(int'(t[SYM_W-1:0])) : CHAR_W'($urandom);
        t = t >> SYM_W;
      end
      n    = CODE_CHARS;
      flaw = $urandom_range(0, 99);
      if (flaw < 12) begin
        n = $urandom_range(1, CODE_CHARS - 1);
      end else if (flaw < 22) begin
        text[$urandom_range(0, CODE_CHARS - 1)] = CHAR_W'($urandom);
      end else if (flaw < 32) begin
        text[CODE_CHARS-1] = symbol_char($urandom_range(TOP_SYM_MAX + 1, SYMS - 1));
      end else if (flaw < 42) begin
        n = CODE_CHARS + $urandom_range(1, 5);
      end
      for (int k = 0; k < n; k++) begin
        // an encode in mid-run must leave the run alone
        if ($urandom_range(0, 19) == 0) begin
          send_request(OP_ENCODE, {$urandom, $urandom}, '0, 1'b0, 1'b0);
        end
        send_request(OP_DECODE, '0, text[k], k == n - 1, 1'b0);
      end
    end
  endtask

  task automatic report_field(input string name, input logic [ID_W-1:0] want,
                              input logic [ID_W-1:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  // result side: compare every popped result with the oldest one queued
  initial begin
    code_result_t got;
    code_result_t want;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got = '{kind_e'(kind_o), out_char_o, out_last_o, id_out_o, valid_res_o};
        if (awaited_results.size() == 0) begin
          mismatches++;
          $display("%0t: result with none awaited, expected nothing, actual %p", $time, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.kind !== want.kind) begin
            report_field("kind", ID_W'(want.kind), ID_W'(got.kind));
          end
          if (got.ch !== want.ch) begin
            report_field("out_char", ID_W'(want.ch), ID_W'(got.ch));
          end
          if (got.last !== want.last) begin
            report_field("out_last", ID_W'(want.last), ID_W'(got.last));
          end
          if (got.id !== want.id) report_field("id_out", want.id, got.id);
          if (got.valid !== want.valid) begin
            report_field("valid_res", ID_W'(want.valid), ID_W'(got.valid));
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= pop_gap_pct);
    end
  end

  // watchdog: nothing moving on either side for too long ends the run
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stalled = 0;
      else stalled++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // request side: reset, opening table, then three random phases
  initial begin
    clear_run();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gap_pct = 10;
    pop_gap_pct  = 64;
    foreach (opening_rows[r]) begin
      send_request(opening_rows[r].op, opening_rows[r].id, opening_rows[r].ch,
                   opening_rows[r].last, opening_rows[r].malformed);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        1: begin
          // pause until the queue is drained, then swap who idles
          settle_results();
          send_gap_pct = 64;
          pop_gap_pct  = 10;
        end
        2: begin
          settle_results();
          send_gap_pct = 0;
          pop_gap_pct  = 0;
        end
        default: ;
      endcase
      while (items_sent < OPENING_ROWS + RANDOM_ITEMS / 3 * (phase + 1)) random_burst();
    end

    settle_results();
    // stray results would show up within the back-end latency
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/lcgc_pkg.sv
sv/lcgc_front.sv
sv/lcgc_queue.sv
sv/lcgc_back.sv
sv/lcg_id_text_codec.sv
sv/lcgc_checker.sv
tb/sv/testbench.sv
